[rtl/sic_pkg.sv]
package sic_pkg;

    // Default coordinate width; the top level may override it (range 4 to 30).
    localparam int COORD_BITS_DEF = 15;

    typedef enum logic [2:0] {
        KIND_NONE            = 3'd0,
        KIND_END_TO_END      = 3'd1,
        KIND_END_ON_INTERIOR = 3'd2,
        KIND_CROSSING        = 3'd3,
        KIND_OVERLAP         = 3'd4
    } kind_t;

endpackage

[rtl/sic_classify.sv]
module sic_classify
    import sic_pkg::*;
#(
    parameter int XW = 33
) (
    input  logic signed [XW-1:0] det,
    input  logic signed [XW-1:0] lam_num,
    input  logic signed [XW-1:0] mu_num,
    input  kind_t                coll_kind,
    output kind_t                kind
);

    logic det_pos;
    logic l_end;
    logic m_end;
    logic l_in;
    logic m_in;

    always_comb
    begin
        det_pos = !det[XW-1];
        l_end   = (lam_num == '0) || (lam_num == det);
        m_end   = (mu_num == '0) || (mu_num == det);
        // A parameter is strictly inside (0,1) when its numerator lies strictly
        // between zero and the determinant, whatever the determinant's sign.
        if (det_pos)
        begin
            l_in = (lam_num > 0) && (lam_num < det);
            m_in = (mu_num > 0) && (mu_num < det);
        end
        else
        begin
            l_in = (lam_num < 0) && (lam_num > det);
            m_in = (mu_num < 0) && (mu_num > det);
        end

        if (det != '0)
        begin
            if (l_end && m_end)
                kind = KIND_END_TO_END;
            else if ((l_end && m_in) || (m_end && l_in))
                kind = KIND_END_ON_INTERIOR;
            else if (l_in && m_in)
                kind = KIND_CROSSING;
            else
                kind = KIND_NONE;
        end
        else if ((lam_num == '0) && (mu_num == '0))
        begin
            kind = coll_kind;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

endmodule

[rtl/segment_intersection_classifier_unit.sv]
// Throughput: one segment pair per cycle while the output is not stalled; the five register stages (input, differences,
// products, determinants, result) each hold one item and advance independently.
// Reset: rst_n clears all stage valid flags asynchronously, so the pipeline comes up empty
// with in_ready high; data registers are not reset.
module segment_intersection_classifier_unit
    import sic_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] a1_x,
    input  logic signed [COORD_BITS-1:0] a1_y,
    input  logic signed [COORD_BITS-1:0] a2_x,
    input  logic signed [COORD_BITS-1:0] a2_y,
    input  logic signed [COORD_BITS-1:0] b1_x,
    input  logic signed [COORD_BITS-1:0] b1_y,
    input  logic signed [COORD_BITS-1:0] b2_x,
    input  logic signed [COORD_BITS-1:0] b2_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   contact_kind
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    // Stage valid flags and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic adv1, adv2, adv3, adv4, adv_out;

    // Stage 1: input register.
    logic signed [CW-1:0] a1x_reg, a1y_reg, a2x_reg, a2y_reg;
    logic signed [CW-1:0] b1x_reg, b1y_reg, b2x_reg, b2y_reg;

    // Stage 2: direction vectors and sorted intervals on both axes.
    logic signed [DW-1:0] dax_next, day_next, dbx_next, dby_next, ex_next, ey_next;
    logic signed [DW-1:0] dax_reg, day_reg, dbx_reg, dby_reg, ex_reg, ey_reg;
    logic signed [CW-1:0] axlo_next, axhi_next, bxlo_next, bxhi_next;
    logic signed [CW-1:0] aylo_next, ayhi_next, bylo_next, byhi_next;
    logic signed [CW-1:0] axlo_reg, axhi_reg, bxlo_reg, bxhi_reg;
    logic signed [CW-1:0] aylo_reg, ayhi_reg, bylo_reg, byhi_reg;

    // Stage 3: cross products and the collinear interval on the chosen axis.
    logic signed [PW-1:0] pd1_next, pd2_next, pl1_next, pl2_next, pm1_next, pm2_next;
    logic signed [PW-1:0] pd1_reg, pd2_reg, pl1_reg, pl2_reg, pm1_reg, pm2_reg;
    logic                 a_pt, b_pt;
    logic signed [DW-1:0] rx, ry;
    logic [DW-1:0]        rx_mag, ry_mag;
    logic signed [CW-1:0] alo_next, ahi_next, blo_next, bhi_next;
    logic signed [CW-1:0] alo_reg, ahi_reg, blo_reg, bhi_reg;
    logic                 both_pt_next, pts_eq_next;
    logic                 both_pt_reg, pts_eq_reg;

    // Stage 4: determinants and the collinear verdict.
    logic signed [XW-1:0] d_next, l_next, m_next;
    logic signed [XW-1:0] d_reg, l_reg, m_reg;
    kind_t                coll_next, coll_reg;

    // Result register.
    kind_t                kind_next, out_kind_reg;

    // A stage may load when it is empty or its content moves on in the same cycle.
    assign adv_out  = !out_valid_reg || out_ready;
    assign adv4     = !v4_reg || adv_out;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
            if (adv_out)
                out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            a1x_reg <= a1_x;
            a1y_reg <= a1_y;
            a2x_reg <= a2_x;
            a2y_reg <= a2_y;
            b1x_reg <= b1_x;
            b1y_reg <= b1_y;
            b2x_reg <= b2_x;
            b2y_reg <= b2_y;
        end
    end

    always_comb
    begin
        dax_next  = DW'(a2x_reg) - DW'(a1x_reg);
        day_next  = DW'(a2y_reg) - DW'(a1y_reg);
        dbx_next  = DW'(b1x_reg) - DW'(b2x_reg);
        dby_next  = DW'(b1y_reg) - DW'(b2y_reg);
        ex_next   = DW'(b1x_reg) - DW'(a1x_reg);
        ey_next   = DW'(b1y_reg) - DW'(a1y_reg);
        axlo_next = (a1x_reg < a2x_reg) ? a1x_reg : a2x_reg;
        axhi_next = (a1x_reg < a2x_reg) ? a2x_reg : a1x_reg;
        bxlo_next = (b1x_reg < b2x_reg) ? b1x_reg : b2x_reg;
        bxhi_next = (b1x_reg < b2x_reg) ? b2x_reg : b1x_reg;
        aylo_next = (a1y_reg < a2y_reg) ? a1y_reg : a2y_reg;
        ayhi_next = (a1y_reg < a2y_reg) ? a2y_reg : a1y_reg;
        bylo_next = (b1y_reg < b2y_reg) ? b1y_reg : b2y_reg;
        byhi_next = (b1y_reg < b2y_reg) ? b2y_reg : b1y_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            dax_reg  <= dax_next;
            day_reg  <= day_next;
            dbx_reg  <= dbx_next;
            dby_reg  <= dby_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            axlo_reg <= axlo_next;
            axhi_reg <= axhi_next;
            bxlo_reg <= bxlo_next;
            bxhi_reg <= bxhi_next;
            aylo_reg <= aylo_next;
            ayhi_reg <= ayhi_next;
            bylo_reg <= bylo_next;
            byhi_reg <= byhi_next;
        end
    end

    always_comb
    begin
        pd1_next = PW'(dax_reg) * PW'(dby_reg);
        pd2_next = PW'(day_reg) * PW'(dbx_reg);
        pl1_next = PW'(ex_reg) * PW'(dby_reg);
        pl2_next = PW'(ey_reg) * PW'(dbx_reg);
        pm1_next = PW'(dax_reg) * PW'(ey_reg);
        pm2_next = PW'(day_reg) * PW'(ex_reg);

        a_pt = (dax_reg == '0) && (day_reg == '0);
        b_pt = (dbx_reg == '0) && (dby_reg == '0);
        // The reference direction falls back to B's when A is a single point;
        // only its magnitudes matter, so B's sign does not need flipping.
        rx = a_pt ? dbx_reg : dax_reg;
        ry = a_pt ? dby_reg : day_reg;
        rx_mag = rx[DW-1] ? DW'(-rx) : DW'(rx);
        ry_mag = ry[DW-1] ? DW'(-ry) : DW'(ry);
        if (rx_mag > ry_mag)
        begin
            alo_next = axlo_reg;
            ahi_next = axhi_reg;
            blo_next = bxlo_reg;
            bhi_next = bxhi_reg;
        end
        else
        begin
            alo_next = aylo_reg;
            ahi_next = ayhi_reg;
            blo_next = bylo_reg;
            bhi_next = byhi_reg;
        end
        both_pt_next = a_pt && b_pt;
        pts_eq_next  = (ex_reg == '0) && (ey_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            pd1_reg     <= pd1_next;
            pd2_reg     <= pd2_next;
            pl1_reg     <= pl1_next;
            pl2_reg     <= pl2_next;
            pm1_reg     <= pm1_next;
            pm2_reg     <= pm2_next;
            alo_reg     <= alo_next;
            ahi_reg     <= ahi_next;
            blo_reg     <= blo_next;
            bhi_reg     <= bhi_next;
            both_pt_reg <= both_pt_next;
            pts_eq_reg  <= pts_eq_next;
        end
    end

    always_comb
    begin
        d_next = XW'(pd1_reg) - XW'(pd2_reg);
        l_next = XW'(pl1_reg) - XW'(pl2_reg);
        m_next = XW'(pm1_reg) - XW'(pm2_reg);
        if (both_pt_reg)
            coll_next = pts_eq_reg ? KIND_END_TO_END : KIND_NONE;
        else if ((ahi_reg < blo_reg) || (alo_reg > bhi_reg))
            coll_next = KIND_NONE;
        else if ((ahi_reg == blo_reg) || (alo_reg == bhi_reg))
            coll_next = KIND_END_TO_END;
        else
            coll_next = KIND_OVERLAP;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            d_reg    <= d_next;
            l_reg    <= l_next;
            m_reg    <= m_next;
            coll_reg <= coll_next;
        end
    end

    sic_classify #(
        .XW(XW)
    ) u_classify (
        .det       (d_reg),
        .lam_num   (l_reg),
        .mu_num    (m_reg),
        .coll_kind (coll_reg),
        .kind      (kind_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv_out)
            out_kind_reg <= kind_next;
    end

    assign out_valid    = out_valid_reg;
    assign contact_kind = out_kind_reg;

endmodule

[rtl/sic_checker.sv]
module sic_checker
    import sic_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] contact_kind
);

    // A stalled result keeps its value until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(contact_kind))
        else $error("result changed or vanished while stalled");

    // The result code is always one of the defined kinds.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> contact_kind <= KIND_OVERLAP)
        else $error("undefined contact kind");

    // With the output side free to move, nothing may hold back the input.
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled while the output was free");

    // Directly after reset the pipeline is empty.
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && in_ready)
        else $error("pipeline not empty after reset");

endmodule

bind segment_intersection_classifier_unit sic_checker u_sic_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .contact_kind (contact_kind)
);

[sim/tb_segment_intersection_classifier_unit.sv]
`timescale 1ns / 100ps

module tb_segment_intersection_classifier_unit;
    import sic_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_PER_PHASE = 400;
    localparam int NUM_DIRECTED = 22;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t a1x;
        coord_t a1y;
        coord_t a2x;
        coord_t a2y;
        coord_t b1x;
        coord_t b1y;
        coord_t b2x;
        coord_t b2y;
    } seg_pair_t;

    typedef struct packed {
        seg_pair_t pair;
        logic      typed;
        kind_t     kind;
    } directed_row_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_ready;
    coord_t a1_x;
    coord_t a1_y;
    coord_t a2_x;
    coord_t a2_y;
    coord_t b1_x;
    coord_t b1_y;
    coord_t b2_x;
    coord_t b2_y;
    logic   out_valid;
    logic   out_ready;
    logic [2:0] contact_kind;

    kind_t  kind_q[$];
    int     failures = 0;
    int     cycle_count;
    int     idle_pct;
    int     stall_pct;

    // Rows with typed = 1 carry an expectation that is obvious from the geometry.
    directed_row_t directed_tab[NUM_DIRECTED] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, KIND_END_TO_END},
        '{'{0, 0, 0, 0, 1, 0, 1, 0}, 1'b1, KIND_NONE},
        '{'{-10, 0, 10, 0, 0, -10, 0, 10}, 1'b1, KIND_CROSSING},
        '{'{0, 0, 10, 0, 10, 0, 10, 10}, 1'b1, KIND_END_TO_END},
        '{'{0, 0, 10, 0, 5, 0, 5, 10}, 1'b1, KIND_END_ON_INTERIOR},
        '{'{0, 0, 10, 0, 0, 5, 10, 5}, 1'b1, KIND_NONE},
        '{'{0, 0, 10, 0, 5, 0, 15, 0}, 1'b1, KIND_OVERLAP},
        '{'{0, 0, 10, 0, 10, 0, 20, 0}, 1'b1, KIND_END_TO_END},
        '{'{0, 0, 10, 0, 11, 0, 20, 0}, 1'b1, KIND_NONE},
        '{'{0, 0, 10, 0, 5, 3, 5, 3}, 1'b1, KIND_NONE},
        '{'{0, 0, 10, 0, 5, 0, 5, 0}, 1'b1, KIND_OVERLAP},
        '{'{3, 3, 3, 3, 3, 3, 9, 9}, 1'b1, KIND_END_TO_END},
        '{'{-16384, -16384, 16383, 16383, -16384, 16383, 16383, -16384}, 1'b1,
          KIND_CROSSING},
        '{'{-16384, -16384, 16383, 16383, -16384, -16384, 16383, 16383}, 1'b1,
          KIND_OVERLAP},
        '{'{16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383}, 1'b1,
          KIND_END_TO_END},
        '{'{-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384}, 1'b1,
          KIND_END_TO_END},
        '{'{10, 0, 0, 0, 0, -5, 0, 5}, 1'b1, KIND_END_ON_INTERIOR},
        '{'{0, 0, 10, 0, 20, -5, 20, 5}, 1'b1, KIND_NONE},
        '{'{-16384, 16383, 16383, -16384, -16384, -16384, 0, 0}, 1'b0, KIND_NONE},
        '{'{16383, 16383, -16384, -16384, 16383, -16384, 16383, 16383}, 1'b0,
          KIND_NONE},
        '{'{10922, -10923, -10923, 10922, -10923, -10923, 10922, 10922}, 1'b0,
          KIND_NONE},
        '{'{1, 1, 3, 3, 2, 2, 5, 5}, 1'b0, KIND_NONE}
    };

    segment_intersection_classifier_unit #(
        .COORD_BITS(CW)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .a1_x(a1_x),
        .a1_y(a1_y),
        .a2_x(a2_x),
        .a2_y(a2_y),
        .b1_x(b1_x),
        .b1_y(b1_y),
        .b2_x(b2_x),
        .b2_y(b2_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .contact_kind(contact_kind)
    );

    function automatic bit param_at_end(input longint n, input longint d);
        return n == 0 || n == d;
    endfunction

    function automatic bit param_inside(input longint n, input longint d);
        if (d > 0)
        begin
            return n > 0 && n < d;
        end
        return n < 0 && n > d;
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic kind_t classify_contact(input seg_pair_t p);
        longint a1x = $signed(p.a1x);
        longint a1y = $signed(p.a1y);
        longint a2x = $signed(p.a2x);
        longint a2y = $signed(p.a2y);
        longint b1x = $signed(p.b1x);
        longint b1y = $signed(p.b1y);
        longint b2x = $signed(p.b2x);
        longint b2y = $signed(p.b2y);
        longint dax = a2x - a1x;
        longint day = a2y - a1y;
        longint dbx = b1x - b2x;
        longint dby = b1y - b2y;
        longint ex = b1x - a1x;
        longint ey = b1y - a1y;
        longint det = dax * dby - day * dbx;
        longint lam = ex * dby - ey * dbx;
        longint mu = dax * ey - day * ex;
        longint rx;
        longint ry;
        longint alo;
        longint ahi;
        longint blo;
        longint bhi;
        bit     le;
        bit     me;
        bit     li;
        bit     mi;

        if (det != 0)
        begin
            le = param_at_end(lam, det);
            me = param_at_end(mu, det);
            li = !le && param_inside(lam, det);
            mi = !me && param_inside(mu, det);
            if (le && me)
            begin
                return KIND_END_TO_END;
            end
            if ((le && mi) || (me && li))
            begin
                return KIND_END_ON_INTERIOR;
            end
            if (li && mi)
            begin
                return KIND_CROSSING;
            end
            return KIND_NONE;
        end
        if (lam != 0 || mu != 0)
        begin
            return KIND_NONE;
        end
        // Collinear: take the direction of A, or of B when A is a single point.
        rx = dax;
        ry = day;
        if (rx == 0 && ry == 0)
        begin
            rx = -dbx;
            ry = -dby;
        end
        if (rx == 0 && ry == 0)
        begin
            return (a1x == b1x && a1y == b1y) ? KIND_END_TO_END : KIND_NONE;
        end
        if (magnitude(rx) > magnitude(ry))
        begin
            alo = a1x < a2x ? a1x : a2x;
            ahi = a1x < a2x ? a2x : a1x;
            blo = b1x < b2x ? b1x : b2x;
            bhi = b1x < b2x ? b2x : b1x;
        end
        else
        begin
            alo = a1y < a2y ? a1y : a2y;
            ahi = a1y < a2y ? a2y : a1y;
            blo = b1y < b2y ? b1y : b2y;
            bhi = b1y < b2y ? b2y : b1y;
        end
        if (ahi < blo || alo > bhi)
        begin
            return KIND_NONE;
        end
        if (ahi == blo || alo == bhi)
        begin
            return KIND_END_TO_END;
        end
        return KIND_OVERLAP;
    endfunction

    function automatic int spread(input int n);
        return int'($urandom_range(2 * n)) - n;
    endfunction

    function automatic coord_t corner_value();
        case ($urandom_range(4))
            0: return coord_t'(-16384);
            1: return coord_t'(16383);
            2: return coord_t'(0);
            3: return coord_t'(-1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int        bx;
        int        by;
        int        dx;
        int        dy;
        int        k;

        p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(9))
            2:
            begin
                p = '{coord_t'(spread(8)), coord_t'(spread(8)), coord_t'(spread(8)),
                      coord_t'(spread(8)), coord_t'(spread(8)), coord_t'(spread(8)),
                      coord_t'(spread(8)), coord_t'(spread(8))};
            end
            3:
            begin
                // Four points on one line, so every pair is collinear.
                bx = spread(2000);
                by = spread(2000);
                dx = spread(20);
                dy = spread(20);
                k = spread(50);
                p.a1x = coord_t'(bx + k * dx);
                p.a1y = coord_t'(by + k * dy);
                k = spread(50);
                p.a2x = coord_t'(bx + k * dx);
                p.a2y = coord_t'(by + k * dy);
                k = spread(50);
                p.b1x = coord_t'(bx + k * dx);
                p.b1y = coord_t'(by + k * dy);
                k = spread(50);
                p.b2x = coord_t'(bx + k * dx);
                p.b2y = coord_t'(by + k * dy);
            end
            4:
            begin
                p = '{coord_t'(spread(3000)), coord_t'(spread(3000)),
                      coord_t'(spread(3000)), coord_t'(spread(3000)),
                      coord_t'(spread(3000)), coord_t'(spread(3000)),
                      coord_t'(spread(3000)), coord_t'(spread(3000))};
                if ($urandom_range(1))
                begin
                    p.b1x = $urandom_range(1) ? p.a1x : p.a2x;
                    p.b1y = p.b1x == p.a1x ? p.a1y : p.a2y;
                end
                else
                begin
                    p.b2x = $urandom_range(1) ? p.a1x : p.a2x;
                    p.b2y = p.b2x == p.a1x ? p.a1y : p.a2y;
                end
            end
            5:
            begin
                // One end of one segment sits at the midpoint of the other.
                bx = spread(3000);
                by = spread(3000);
                dx = spread(500);
                dy = spread(500);
                p.a1x = coord_t'(bx);
                p.a1y = coord_t'(by);
                p.a2x = coord_t'(bx + 2 * dx);
                p.a2y = coord_t'(by + 2 * dy);
                p.b1x = coord_t'(spread(3000));
                p.b1y = coord_t'(spread(3000));
                p.b2x = coord_t'(bx + dx);
                p.b2y = coord_t'(by + dy);
                if ($urandom_range(1))
                begin
                    p = '{p.b1x, p.b1y, p.b2x, p.b2y, p.a1x, p.a1y, p.a2x, p.a2y};
                end
            end
            6:
            begin
                p = '{coord_t'(spread(4)), coord_t'(spread(4)), coord_t'(spread(4)),
                      coord_t'(spread(4)), coord_t'(spread(4)), coord_t'(spread(4)),
                      coord_t'(spread(4)), coord_t'(spread(4))};
                if ($urandom_range(1))
                begin
                    p.a2x = p.a1x;
                    p.a2y = p.a1y;
                end
                if ($urandom_range(1))
                begin
                    p.b2x = p.b1x;
                    p.b2y = p.b1y;
                end
            end
            7:
            begin
                p = '{corner_value(), corner_value(), corner_value(), corner_value(),
                      corner_value(), corner_value(), corner_value(), corner_value()};
            end
            8, 9:
            begin
                p = '{coord_t'(spread(200)), coord_t'(spread(200)),
                      coord_t'(spread(200)), coord_t'(spread(200)),
                      coord_t'(spread(200)), coord_t'(spread(200)),
                      coord_t'(spread(200)), coord_t'(spread(200))};
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    // Called in the time step of a clock edge; returns in the step of the
    // edge at which the transfer took place.
    task automatic send_pair(input seg_pair_t p, input kind_t kind);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        a1_x <= p.a1x;
        a1_y <= p.a1y;
        a2_x <= p.a2x;
        a2_y <= p.a2y;
        b1_x <= p.b1x;
        b1_y <= p.b1y;
        b2_x <= p.b2x;
        b2_y <= p.b2y;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        kind_q.push_back(kind);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (kind_q.size() != 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= int'($urandom_range(99)) >= stall_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (kind_q.size() == 0)
            begin
                $error("contact_kind: unexpected transfer, got %0d", contact_kind);
                failures++;
            end
            else
            begin
                if (contact_kind !== kind_q[0])
                begin
                    $error("contact_kind: expected %0d, got %0d", kind_q[0], contact_kind);
                    failures++;
                end
                void'(kind_q.pop_front());
            end
        end
    end

    initial
    begin
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        a1_x = '0;
        a1_y = '0;
        a2_x = '0;
        a2_y = '0;
        b1_x = '0;
        b1_y = '0;
        b2_x = '0;
        b2_y = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tab[i])
        begin
            send_pair(directed_tab[i].pair,
                      directed_tab[i].typed ? directed_tab[i].kind
                                            : classify_contact(directed_tab[i].pair));
        end
        wait_results_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 62 : (phase == 3) ? 35 : 0;
            stall_pct = (phase == 2) ? 62 : (phase == 3) ? 35 : 0;
            repeat (RAND_PER_PHASE)
            begin
                seg_pair_t p;
                p = random_pair();
                send_pair(p, classify_contact(p));
            end
            // The sender holds off here until the pipeline has emptied.
            wait_results_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && kind_q.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sic_pkg.sv
rtl/sic_classify.sv
rtl/segment_intersection_classifier_unit.sv
rtl/sic_checker.sv
sim/tb_segment_intersection_classifier_unit.sv
